### hw/rtl/lmsc_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: shared types and constants
// Payload types of both channels, the geometry view, the queue entry and codes.
// ----------------------------------------------------------------------------
package lmsc_pkg;

   localparam int MAX_DIM     = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int DIV_W       = 12;
   localparam int DIV_STEPS   = DIV_W;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ADDRESS_MODE   = 3'd0,
      CSR_MATRIX_COLUMNS = 3'd1,
      CSR_MATRIX_ROWS    = 3'd2,
      CSR_START_CHANNEL  = 3'd3,
      CSR_FRAME_WIDTH    = 3'd4,
      CSR_FRAME_HEIGHT   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SNAKE_BL = 2'd0,
      MODE_SNAKE_TR = 2'd1,
      MODE_SNAKE_TL = 2'd2,
      MODE_FOUR_DOT = 2'd3
   } address_mode_type;

   typedef enum logic [1:0] {
      GEO_LOAD   = 2'd0,
      GEO_DIVIDE = 2'd1,
      GEO_READY  = 2'd2
   } geo_state_type;

   typedef enum logic [1:0] {
      DIV_CELL_W   = 2'd0,
      DIV_CELL_H   = 2'd1,
      DIV_MARGIN_X = 2'd2,
      DIV_MARGIN_Y = 2'd3
   } div_phase_type;

   typedef struct packed {
      logic [5:0] cell_column;
      logic [5:0] cell_row;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] sample_x;
      logic [11:0] sample_y;
      logic [23:0] pixel_index;
      logic [13:0] dmx_channel;
      logic        past_universe;
      logic        bad_geometry;
   } rsp_payload_type;

   typedef struct packed {
      logic             ready;
      address_mode_type mode;
      logic [6:0]       cols;
      logic [6:0]       rows;
      logic [8:0]       start;
      logic [11:0]      frame_width;
      logic [11:0]      tile;
      logic [10:0]      left;
      logic [10:0]      bottom;
   } geom_type;

   typedef struct packed {
      logic [23:0]        sx;
      logic [23:0]        sy;
      logic signed [13:0] offset;
      logic               bad;
   } work_type;

endpackage

### hw/rtl/lmsc_stream_if.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: stream channel
// Valid and ready handshake with a typed payload; one beat per accepting edge.
// ----------------------------------------------------------------------------
interface lmsc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/led_matrix_sample_and_channel_map_top.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: top level
// Each accepted cell beat passes through the work queue and then the output register.
// Throughput: one beat per cycle while the geometry is ready, limited otherwise only by
// the output side taking results. After reset and every register write, req_chan.ready
// stays low while the shared divider derives tile size and margins in four divisions.
// Reset is synchronous; it restores the register defaults and empties the queue.
// ----------------------------------------------------------------------------
module led_matrix_sample_and_channel_map_top (
   input  logic                                clock,
   input  logic                                reset,
   lmsc_stream_if.sink                         req_chan,
   lmsc_stream_if.source                       rsp_chan,
   input  logic                                csr_we,
   input  logic [lmsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lmsc_pkg::*;

   geom_type geom;
   work_type work;
   work_type head;
   logic     head_valid;
   logic     full;
   logic     push;
   logic     pop;

   lmsc_geometry u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   assign req_chan.ready = geom.ready && !full;
   assign push           = req_chan.valid && req_chan.ready;

   lmsc_front u_front (
      .req_payload (req_chan.payload),
      .geom        (geom),
      .work        (work)
   );

   lmsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (work),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   lmsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .geom       (geom),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

### hw/rtl/lmsc_geometry.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: geometry unit
// Holds the control registers and derives tile size and margins with a
// shared restoring divider whenever the registers change.
// ----------------------------------------------------------------------------
module lmsc_geometry (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lmsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmsc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lmsc_pkg::geom_type                  geom
);
   import lmsc_pkg::*;

   address_mode_type mode_ff;
   logic [6:0]       cols_ff;
   logic [6:0]       rows_ff;
   logic [8:0]       start_ff;
   logic [11:0]      fw_ff;
   logic [11:0]      fh_ff;

   geo_state_type    state_ff, state_in;
   div_phase_type    phase_ff, phase_in;
   logic [3:0]       count_ff, count_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [11:0]      cw_ff, cw_in;
   logic [11:0]      tile_ff, tile_in;
   logic [10:0]      left_ff, left_in;
   logic [10:0]      bottom_ff, bottom_in;

   logic [6:0]       cols_sat;
   logic [6:0]       rows_sat;
   logic [DIV_W:0]   shift_w;
   logic [DIV_W+1:0] trial_w;
   logic             fits_w;
   logic [DIV_W-1:0] rem_next;
   logic [DIV_W-1:0] quo_next;

   assign cols_sat = (cols_ff > 7'(MAX_DIM)) ? 7'(MAX_DIM) : cols_ff;
   assign rows_sat = (rows_ff > 7'(MAX_DIM)) ? 7'(MAX_DIM) : rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SNAKE_BL;
         cols_ff  <= 7'd8;
         rows_ff  <= 7'd8;
         start_ff <= 9'd1;
         fw_ff    <= 12'd800;
         fh_ff    <= 12'd600;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ADDRESS_MODE:   mode_ff  <= address_mode_type'(csr_wdata[1:0]);
            CSR_MATRIX_COLUMNS: cols_ff  <= csr_wdata[6:0];
            CSR_MATRIX_ROWS:    rows_ff  <= csr_wdata[6:0];
            CSR_START_CHANNEL:  start_ff <= csr_wdata[8:0];
            CSR_FRAME_WIDTH:    fw_ff    <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT:   fh_ff    <= csr_wdata[11:0];
            default: begin
            end
         endcase
      end
   end

   assign shift_w  = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_w  = {1'b0, shift_w} - {2'b00, div_ff};
   assign fits_w   = !trial_w[DIV_W+1];
   assign rem_next = fits_w ? trial_w[DIV_W-1:0] : shift_w[DIV_W-1:0];
   assign quo_next = {quo_ff[DIV_W-2:0], fits_w};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEO_LOAD;
         phase_ff <= DIV_CELL_W;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      div_ff    <= div_in;
      cw_ff     <= cw_in;
      tile_ff   <= tile_in;
      left_ff   <= left_in;
      bottom_ff <= bottom_in;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      cw_in     = cw_ff;
      tile_in   = tile_ff;
      left_in   = left_ff;
      bottom_in = bottom_ff;
      unique case (state_ff)
         GEO_LOAD: begin
            rem_in   = '0;
            count_in = '0;
            state_in = GEO_DIVIDE;
            unique case (phase_ff)
               DIV_CELL_W: begin
                  quo_in = fw_ff;
                  div_in = {5'd0, cols_sat};
               end
               DIV_CELL_H: begin
                  quo_in = fh_ff;
                  div_in = {5'd0, rows_sat};
               end
               DIV_MARGIN_X: begin
                  quo_in = fw_ff;
                  div_in = tile_ff;
               end
               DIV_MARGIN_Y: begin
                  quo_in = fh_ff;
                  div_in = tile_ff;
               end
            endcase
         end
         GEO_DIVIDE: begin
            rem_in   = rem_next;
            quo_in   = quo_next;
            count_in = count_ff + 4'd1;
            if (count_ff == 4'(DIV_STEPS - 1)) begin
               unique case (phase_ff)
                  DIV_CELL_W: cw_in = quo_next;
                  DIV_CELL_H: begin
                     if (cols_sat == 7'd0 || rows_sat == 7'd0) begin
                        tile_in = '0;
                     end else begin
                        tile_in = (cw_ff < quo_next) ? cw_ff : quo_next;
                     end
                  end
                  DIV_MARGIN_X: left_in   = rem_next[DIV_W-1:1];
                  DIV_MARGIN_Y: bottom_in = rem_next[DIV_W-1:1];
               endcase
               if (phase_ff == DIV_MARGIN_Y) begin
                  state_in = GEO_READY;
               end else begin
                  phase_in = div_phase_type'(phase_ff + 2'd1);
                  state_in = GEO_LOAD;
               end
            end
         end
         GEO_READY: begin
         end
         default: state_in = GEO_LOAD;
      endcase
      if (csr_we) begin
         state_in = GEO_LOAD;
         phase_in = DIV_CELL_W;
      end
   end

   assign geom.ready       = (state_ff == GEO_READY);
   assign geom.mode        = mode_ff;
   assign geom.cols        = cols_sat;
   assign geom.rows        = rows_sat;
   assign geom.start       = start_ff;
   assign geom.frame_width = fw_ff;
   assign geom.tile        = tile_ff;
   assign geom.left        = left_ff;
   assign geom.bottom      = bottom_ff;

endmodule

### hw/rtl/lmsc_front.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: front end
// Classifies a cell beat by wiring order, forms the wiring offset and the
// sample coordinates, and hands them to the queue.
// ----------------------------------------------------------------------------
module lmsc_front (
   input  lmsc_pkg::req_payload_type req_payload,
   input  lmsc_pkg::geom_type        geom,
   output lmsc_pkg::work_type        work
);
   import lmsc_pkg::*;

   logic [5:0]         x;
   logic [5:0]         y;
   logic [17:0]        x_tile_w;
   logic [17:0]        y_tile_w;
   logic signed [8:0]  x_s;
   logic signed [8:0]  y_s;
   logic signed [8:0]  cols_s;
   logic signed [8:0]  rows_s;
   logic signed [8:0]  half_s;
   logic signed [8:0]  xh_s;
   logic signed [8:0]  row_term;
   logic signed [8:0]  mult_b;
   logic signed [8:0]  col_term;
   logic signed [15:0] prod_w;
   logic signed [15:0] seg_w;
   logic [1:0]         local_w;
   logic               flip_w;
   logic               bad_w;

   assign x = req_payload.cell_column;
   assign y = req_payload.cell_row;

   assign x_s    = $signed({3'd0, x});
   assign y_s    = $signed({3'd0, y});
   assign cols_s = $signed({2'd0, geom.cols});
   assign rows_s = $signed({2'd0, geom.rows});
   assign half_s = $signed({3'd0, geom.cols[6:1]});
   assign xh_s   = $signed({4'd0, x[5:1]});

   always_comb begin
      flip_w   = 1'b0;
      row_term = y_s;
      mult_b   = cols_s;
      col_term = x_s;
      local_w  = 2'd0;
      unique case (geom.mode)
         MODE_SNAKE_BL: begin
            col_term = y[0] ? (cols_s - 9'sd1 - x_s) : x_s;
         end
         MODE_SNAKE_TR, MODE_SNAKE_TL: begin
            flip_w   = (geom.mode == MODE_SNAKE_TR) ? (geom.rows[0] ^ y[0])
                                                    : !(geom.rows[0] ^ y[0]);
            row_term = rows_s - y_s - 9'sd1;
            col_term = flip_w ? (cols_s - x_s - 9'sd1) : x_s;
         end
         MODE_FOUR_DOT: begin
            row_term = $signed({4'd0, y[5:1]});
            mult_b   = half_s;
            col_term = y[1] ? (half_s - 9'sd1 - xh_s) : xh_s;
            if (y[1]) begin
               local_w = x[0] ? (2'd1 - {1'b0, y[0]}) : (2'd2 + {1'b0, y[0]});
            end else begin
               local_w = x[0] ? (2'd3 - {1'b0, y[0]}) : {1'b0, y[0]};
            end
         end
      endcase
   end

   assign prod_w = 16'(row_term) * 16'(mult_b);
   assign seg_w  = prod_w + 16'(col_term);

   assign x_tile_w = {12'd0, x} * {6'd0, geom.tile};
   assign y_tile_w = {12'd0, y} * {6'd0, geom.tile};
   assign bad_w    = (geom.tile == 12'd0);

   always_comb begin
      work.bad = bad_w;
      if (geom.mode == MODE_FOUR_DOT) begin
         work.offset = 14'((seg_w <<< 2) + $signed({14'd0, local_w}));
      end else begin
         work.offset = 14'(seg_w);
      end
      if (bad_w) begin
         work.sx = '0;
         work.sy = '0;
      end else begin
         work.sx = 24'(geom.left) + 24'(x_tile_w) + 24'(geom.tile[11:1]);
         work.sy = 24'(geom.bottom) + 24'(y_tile_w) + 24'(geom.tile[11:1]);
      end
   end

endmodule

### hw/rtl/lmsc_queue.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: work queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module lmsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lmsc_pkg::work_type push_data,
   input  logic               pop,
   output lmsc_pkg::work_type head,
   output logic               head_valid,
   output logic               full
);
   import lmsc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   work_type             store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head       = store_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));

endmodule

### hw/rtl/lmsc_back.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: back end
// Forms the linear pixel index and the DMX channel of a queued beat and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module lmsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lmsc_pkg::work_type    head,
   input  logic                  head_valid,
   input  lmsc_pkg::geom_type    geom,
   output logic                  pop,
   lmsc_stream_if.source         rsp_chan
);
   import lmsc_pkg::*;

   logic               valid_ff, valid_in;
   rsp_payload_type    payload_ff;
   rsp_payload_type    payload_in;
   logic signed [15:0] off_w;
   logic signed [15:0] chan_w;
   logic [23:0]        pix_w;

   assign pop = head_valid && (!valid_ff || rsp_chan.ready);

   assign off_w  = {{2{head.offset[13]}}, head.offset};
   assign chan_w = $signed({7'd0, geom.start}) + (off_w <<< 1) + off_w;
   assign pix_w  = head.sy * {12'd0, geom.frame_width} + head.sx;

   always_comb begin
      payload_in.sample_x      = head.sx[11:0];
      payload_in.sample_y      = head.sy[11:0];
      payload_in.pixel_index   = pix_w;
      payload_in.dmx_channel   = chan_w[13:0];
      payload_in.past_universe = (chan_w < 16'sd0) || (chan_w > 16'sd510);
      payload_in.bad_geometry  = head.bad;
      valid_in = pop || (valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         payload_ff <= payload_in;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = payload_ff;

endmodule

### tb/led_matrix_sample_and_channel_map_top_tb.sv
// ----------------------------------------------------------------------------
// LED matrix sample and channel map: testbench
// Drives LED coordinates into the block under many register settings and checks
// every result beat against a stored value or an in-bench model of the tile
// sampling and the four DMX wiring orders. A short table of hand-picked cases
// comes first, then random coordinates under random geometry, with random stalls
// on both channels and one long stall on the result side backing up the input.
// ----------------------------------------------------------------------------
module led_matrix_sample_and_channel_map_top_tb;
   import lmsc_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int LEDS_PER_SET   = 25;
   localparam int SETS_PER_PHASE = 7;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int FRAME_MAX      = 4095;
   localparam int START_MAX      = 511;
   localparam int DIM_LIMIT      = 127;

   typedef struct packed {
      logic            reg_write;
      csr_index_type   reg_index;
      logic [11:0]     reg_value;
      req_payload_type led;
      logic            known;
      rsp_payload_type known_map;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lmsc_stream_if #(.payload_type(req_payload_type)) req_chan ();
   lmsc_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   led_matrix_sample_and_channel_map_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   address_mode_type cfg_mode;
   logic [6:0]       cfg_cols;
   logic [6:0]       cfg_rows;
   logic [8:0]       cfg_start;
   logic [11:0]      cfg_frame_w;
   logic [11:0]      cfg_frame_h;

   rsp_payload_type  pending_led_maps[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               holds_asked   = 0;
   int               holds_done    = 0;
   int               hold_left     = 0;
   int               quiet_cycles  = 0;
   int               failures      = 0;
   int               leds_sent     = 0;
   int               reg_writes    = 0;
   int               bad_seen      = 0;
   int               past_seen     = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic rsp_payload_type map_led(input req_payload_type led);
      int          x, y, cols, rows, offset, half, seg, slot, chan;
      int unsigned fw, fh, tile, cell_w, cell_h, left, bottom, sx, sy, pix;
      bit          flip;
      rsp_payload_type r;
      x    = int'(led.cell_column);
      y    = int'(led.cell_row);
      cols = (cfg_cols > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
      rows = (cfg_rows > MAX_DIM) ? MAX_DIM : int'(cfg_rows);
      fw   = int'(cfg_frame_w);
      fh   = int'(cfg_frame_h);
      tile = 0;
      sx   = 0;
      sy   = 0;
      pix  = 0;
      if (cols != 0 && rows != 0) begin
         cell_w = fw / cols;
         cell_h = fh / rows;
         tile   = (cell_w > cell_h) ? cell_h : cell_w;
      end
      if (tile != 0) begin
         left   = (fw - tile * (fw / tile)) / 2;
         bottom = (fh - tile * (fh / tile)) / 2;
         sx     = left + x * tile + tile / 2;
         sy     = bottom + y * tile + tile / 2;
         pix    = sy * fw + sx;
      end
      unique case (cfg_mode)
         MODE_SNAKE_BL: begin
            offset = y * cols + (((y & 1) == 0) ? x : cols - 1 - x);
         end
         MODE_SNAKE_TR, MODE_SNAKE_TL: begin
            flip = ((rows - y) & 1) != 0;
            if (cfg_mode == MODE_SNAKE_TL) flip = !flip;
            offset = (rows - y - 1) * cols + (flip ? cols - x - 1 : x);
         end
         default: begin
            half = cols / 2;
            flip = ((y / 2) % 2) != 0;
            seg  = (y / 2) * half + (flip ? half - 1 - x / 2 : x / 2);
            if (!flip) slot = ((x % 2) == 0) ? y % 2 : 3 - y % 2;
            else       slot = ((x % 2) == 0) ? 2 + y % 2 : 1 - y % 2;
            offset = seg * 4 + slot;
         end
      endcase
      chan = int'(cfg_start) + 3 * offset;
      r.sample_x      = sx[11:0];
      r.sample_y      = sy[11:0];
      r.pixel_index   = pix[23:0];
      r.dmx_channel   = chan[13:0];
      r.past_universe = (chan < 0) || (chan + 2 > 512);
      r.bad_geometry  = (tile == 0);
      return r;
   endfunction

   function automatic directed_row_type reg_row(input csr_index_type index, input int value);
      directed_row_type row;
      row           = '0;
      row.reg_write = 1'b1;
      row.reg_index = index;
      row.reg_value = value[11:0];
      return row;
   endfunction

   function automatic directed_row_type led_row(input int column, input int row_no);
      directed_row_type row;
      row                 = '0;
      row.led.cell_column = column[5:0];
      row.led.cell_row    = row_no[5:0];
      return row;
   endfunction

   function automatic directed_row_type known_row(input int column, input int row_no,
                                                  input int sx, input int sy, input int pix,
                                                  input int dmx, input int past, input int bad);
      directed_row_type row;
      row                         = led_row(column, row_no);
      row.known                   = 1'b1;
      row.known_map.sample_x      = sx[11:0];
      row.known_map.sample_y      = sy[11:0];
      row.known_map.pixel_index   = pix[23:0];
      row.known_map.dmx_channel   = dmx[13:0];
      row.known_map.past_universe = past[0];
      row.known_map.bad_geometry  = bad[0];
      return row;
   endfunction

   function automatic int unsigned pick_dim();
      unique case ($urandom_range(15))
         0:             return 0;
         1:             return MAX_DIM;
         2:             return $urandom_range(DIM_LIMIT, MAX_DIM + 1);
         3, 4:          return 1;
         5, 6, 7, 8, 9: return $urandom_range(16, 1);
         default:       return $urandom_range(MAX_DIM, 1);
      endcase
   endfunction

   function automatic int unsigned pick_frame();
      unique case ($urandom_range(15))
         0:       return 0;
         1:       return FRAME_MAX;
         2:       return $urandom_range(MAX_DIM, 1);
         default: return $urandom_range(FRAME_MAX, 1);
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   task automatic offer_led(input req_payload_type led, input logic known,
                            input rsp_payload_type known_map);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= led;
      do @(posedge clock); while (!req_chan.ready);
      pending_led_maps.push_back(known ? known_map : map_led(led));
      leds_sent++;
   endtask

   task automatic write_reg(input csr_index_type index, input int unsigned value);
      req_chan.valid <= 1'b0;
      while (pending_led_maps.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      unique case (index)
         CSR_ADDRESS_MODE:   cfg_mode    = address_mode_type'(value[1:0]);
         CSR_MATRIX_COLUMNS: cfg_cols    = value[6:0];
         CSR_MATRIX_ROWS:    cfg_rows    = value[6:0];
         CSR_START_CHANNEL:  cfg_start   = value[8:0];
         CSR_FRAME_WIDTH:    cfg_frame_w = value[11:0];
         CSR_FRAME_HEIGHT:   cfg_frame_h = value[11:0];
         default:            ;
      endcase
      reg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_settings(input int unsigned mode, input int unsigned cols,
                                 input int unsigned rows, input int unsigned start,
                                 input int unsigned frame_w, input int unsigned frame_h);
      write_reg(CSR_ADDRESS_MODE, mode);
      write_reg(CSR_MATRIX_COLUMNS, cols);
      write_reg(CSR_MATRIX_ROWS, rows);
      write_reg(CSR_START_CHANNEL, start);
      write_reg(CSR_FRAME_WIDTH, frame_w);
      write_reg(CSR_FRAME_HEIGHT, frame_h);
   endtask

   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         hold_left  = HOLD_CYCLES;
         holds_done = holds_asked;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_maps
      rsp_payload_type want;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_led_maps.size() == 0) begin
            $error("Result beat with no LED waiting: %h", rsp_chan.payload);
            failures++;
         end else begin
            want = pending_led_maps.pop_front();
            check_field("sample_x", want.sample_x, rsp_chan.payload.sample_x);
            check_field("sample_y", want.sample_y, rsp_chan.payload.sample_y);
            check_field("pixel_index", want.pixel_index, rsp_chan.payload.pixel_index);
            check_field("dmx_channel", want.dmx_channel, rsp_chan.payload.dmx_channel);
            check_field("past_universe", want.past_universe, rsp_chan.payload.past_universe);
            check_field("bad_geometry", want.bad_geometry, rsp_chan.payload.bad_geometry);
            bad_seen  += int'(want.bad_geometry);
            past_seen += int'(want.past_universe);
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("No beat moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      directed_row_type directed_rows[$];
      directed_row_type row;
      req_payload_type  led;
      int unsigned      eff_cols, eff_rows;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_ADDRESS_MODE;
      csr_wdata        <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      cfg_mode    = MODE_SNAKE_BL;
      cfg_cols    = 7'd8;
      cfg_rows    = 7'd8;
      cfg_start   = 9'd1;
      cfg_frame_w = 12'd800;
      cfg_frame_h = 12'd600;
      send_idle_pct = 29;
      recv_idle_pct = 76;
      directed_rows = '{
         known_row(0, 0, 62, 37, 29662, 1, 0, 0),
         known_row(63, 63, 691, 666, 3814387, 1345, 1, 0),
         led_row(7, 0),
         led_row(0, 1),
         led_row(5, 6),
         reg_row(CSR_ADDRESS_MODE, MODE_SNAKE_TR),
         led_row(0, 0),
         led_row(7, 7),
         led_row(2, 4),
         reg_row(CSR_ADDRESS_MODE, MODE_SNAKE_TL),
         led_row(0, 0),
         led_row(3, 5),
         led_row(6, 7),
         reg_row(CSR_ADDRESS_MODE, MODE_FOUR_DOT),
         led_row(1, 0),
         led_row(1, 1),
         led_row(0, 2),
         led_row(5, 3),
         led_row(63, 0),
         reg_row(CSR_START_CHANNEL, START_MAX),
         known_row(0, 0, 62, 37, 29662, 511, 1, 0),
         reg_row(CSR_START_CHANNEL, 0),
         led_row(7, 7),
         reg_row(CSR_FRAME_WIDTH, 0),
         known_row(2, 1, 0, 0, 0, 15, 0, 1),
         reg_row(CSR_FRAME_WIDTH, FRAME_MAX),
         reg_row(CSR_MATRIX_COLUMNS, 0),
         led_row(3, 3),
         reg_row(CSR_MATRIX_COLUMNS, DIM_LIMIT),
         reg_row(CSR_MATRIX_ROWS, 1),
         reg_row(CSR_FRAME_HEIGHT, FRAME_MAX),
         led_row(63, 0),
         led_row(63, 63),
         reg_row(CSR_MATRIX_ROWS, DIM_LIMIT),
         led_row(63, 63),
         reg_row(CSR_MATRIX_COLUMNS, 2),
         reg_row(CSR_MATRIX_ROWS, 2),
         reg_row(CSR_ADDRESS_MODE, MODE_SNAKE_TR),
         led_row(63, 63),
         reg_row(CSR_FRAME_HEIGHT, 1),
         led_row(0, 0)
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.reg_write) write_reg(row.reg_index, row.reg_value);
         else offer_led(row.led, row.known, row.known_map);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 76 : 0;
         recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 29 : 0;
         for (int setting = 0; setting < SETS_PER_PHASE; setting++) begin
            if (phase == 0 && setting == 0) begin
               write_settings(MODE_FOUR_DOT, MAX_DIM, MAX_DIM, START_MAX, FRAME_MAX, FRAME_MAX);
            end else if (phase == 0 && setting == 1) begin
               write_settings(MODE_SNAKE_BL, 1, 1, 0, 1, 1);
            end else begin
               write_settings($urandom_range(3), pick_dim(), pick_dim(),
                              $urandom_range(START_MAX), pick_frame(), pick_frame());
            end
            if (phase == 2 && setting == 0) holds_asked++;
            eff_cols = (cfg_cols > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
            eff_rows = (cfg_rows > MAX_DIM) ? MAX_DIM : int'(cfg_rows);
            repeat (LEDS_PER_SET) begin
               if ($urandom_range(4) != 0 && eff_cols != 0 && eff_rows != 0) begin
                  led.cell_column = 6'($urandom_range(eff_cols - 1));
                  led.cell_row    = 6'($urandom_range(eff_rows - 1));
               end else begin
                  led = req_payload_type'(12'($urandom_range(4095)));
               end
               offer_led(led, 1'b0, '0);
            end
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_led_maps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Mapped %0d LEDs across %0d register writes in all four wiring orders.",
               leds_sent, reg_writes);
      $display("%0d results had bad geometry and %0d ran past channel 512.",
               bad_seen, past_seen);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### led_matrix_sample_and_channel_map_top.f
hw/rtl/lmsc_pkg.sv
hw/rtl/lmsc_stream_if.sv
hw/rtl/lmsc_geometry.sv
hw/rtl/lmsc_front.sv
hw/rtl/lmsc_queue.sv
hw/rtl/lmsc_back.sv
hw/rtl/led_matrix_sample_and_channel_map_top.sv
tb/led_matrix_sample_and_channel_map_top_tb.sv
